// File: src/amq_pkg.sv
// ----------------------------------------------------------------------------
// amq_pkg
// Types, constants and helpers shared by the array max-priority queue.
// ----------------------------------------------------------------------------
package amq_pkg;

	// Storage geometry.
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Field widths.
	localparam int VAL_W  = 32;
	localparam int PRI_W  = 16;
	localparam int ENT_W  = VAL_W + PRI_W;
	localparam int STAT_W = 2;
	localparam int HELD_W = 7;

	// Operation codes.
	localparam logic KIND_INSERT  = 1'b0;
	localparam logic KIND_EXTRACT = 1'b1;

	// Status codes.
	typedef enum logic [STAT_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MOVE,
		ST_FIN
	} state_t;

	// Input item.
	typedef struct packed {
		logic                    kind;
		logic signed [VAL_W-1:0] value;
		logic [PRI_W-1:0]        priority_req;
	} req_t;

	// Result item.
	typedef struct packed {
		logic signed [VAL_W-1:0] out_value;
		logic [PRI_W-1:0]        out_priority;
		logic [STAT_W-1:0]       status;
		logic [HELD_W-1:0]       held;
		logic                    is_empty;
		logic                    is_full;
	} res_t;

	// Memory access request from the sequencer.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [ENT_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// Builds a result item from the removed pair, a status and the new count.
	function automatic res_t mk_res(input logic signed [VAL_W-1:0] v,
			input logic [PRI_W-1:0] p, input status_t s, input logic [CNT_W-1:0] cnt);
		res_t r;
		r.out_value    = v;
		r.out_priority = p;
		r.status       = s;
		r.held         = HELD_W'(cnt);
		r.is_empty     = (cnt == '0);
		r.is_full      = (cnt == CNT_W'(CAPACITY));
		return r;
	endfunction

endpackage

// File: src/amq_if.sv
// ----------------------------------------------------------------------------
// amq_if
// Valid/ready channels for the queue's input items and result items.
// ----------------------------------------------------------------------------
interface amq_req_if import amq_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    kind;
	logic signed [VAL_W-1:0] value;
	logic [PRI_W-1:0]        priority_req;

	modport source (output valid, kind, value, priority_req, input ready);
	modport sink (input valid, kind, value, priority_req, output ready);
endinterface

interface amq_rsp_if import amq_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] out_value;
	logic [PRI_W-1:0]        out_priority;
	logic [STAT_W-1:0]       status;
	logic [HELD_W-1:0]       held;
	logic                    is_empty;
	logic                    is_full;

	modport source (output valid, out_value, out_priority, status, held, is_empty,
		is_full, input ready);
	modport sink (input valid, out_value, out_priority, status, held, is_empty,
		is_full, output ready);
endinterface

// File: src/array_max_priority_queue_top.sv
// Flow: an insert or a rejected item has its result registered in the sequencer, then
// in the output register; an extract first scans, one memory read per held entry.
// Throughput: one item at a time; the next item is taken once the current result
// is handed to the output register, which may still wait on the sink.
// Reset clears the count and the control state; the entry memory keeps no reset
// value and needs no clearing pass.
// ----------------------------------------------------------------------------
// array_max_priority_queue_top
// Max-priority queue held as an unsorted array in a synchronous RAM.
// ----------------------------------------------------------------------------
module array_max_priority_queue_top import amq_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	amq_req_if.sink   req,
	amq_rsp_if.source rsp
);

	req_t             in_item;
	res_t             res;
	logic             res_valid;
	logic             res_take;
	mem_req_t         mem_req;
	logic [ENT_W-1:0] rdata;
	logic             out_valid_q;
	res_t             out_q;

	assign in_item.kind         = req.kind;
	assign in_item.value        = req.value;
	assign in_item.priority_req = req.priority_req;

	amq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.mem_req   (mem_req),
		.rdata     (rdata)
	);

	amq_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (ENT_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	// Output register: takes a new result when empty or being drained.
	assign res_take = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.out_value    = out_q.out_value;
	assign rsp.out_priority = out_q.out_priority;
	assign rsp.status       = out_q.status;
	assign rsp.held         = out_q.held;
	assign rsp.is_empty     = out_q.is_empty;
	assign rsp.is_full      = out_q.is_full;

endmodule

// File: src/amq_ram.sv
// ----------------------------------------------------------------------------
// amq_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module amq_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, enabled by re.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/amq_ctrl.sv
// ----------------------------------------------------------------------------
// amq_ctrl
// Sequencer: appends on insert, scans memory for the highest priority on
// extract, then moves the last entry into the freed slot.
// ----------------------------------------------------------------------------
module amq_ctrl import amq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  req_t             in_item,
	output logic             res_valid,
	output res_t             res,
	input  logic             res_take,
	output mem_req_t         mem_req,
	input  logic [ENT_W-1:0] rdata
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        iss_q;
	logic                    rv_s1;
	logic [ADDR_W-1:0]       ridx_s1;
	logic signed [VAL_W-1:0] best_val_q;
	logic [PRI_W-1:0]        best_pri_q;
	logic [ADDR_W-1:0]       best_idx_q;
	logic [ENT_W-1:0]        last_q;
	res_t                    res_q;

	logic                    accept;
	logic                    full;
	logic [CNT_W-1:0]        count_dec;
	logic [CNT_W-1:0]        count_inc;
	logic [ADDR_W-1:0]       last_idx;
	logic [PRI_W-1:0]        rd_pri;
	logic signed [VAL_W-1:0] rd_val;
	logic                    take_new;
	logic                    scan_end;

	assign accept    = in_valid && in_ready;
	assign full      = (count_q >= CNT_W'(CAPACITY));
	assign count_dec = count_q - CNT_W'(1);
	assign count_inc = count_q + CNT_W'(1);
	assign last_idx  = count_dec[ADDR_W-1:0];
	assign rd_pri    = rdata[PRI_W-1:0];
	assign rd_val    = rdata[ENT_W-1:PRI_W];
	// The first entry seeds the scan; later ones win only on strictly larger priority.
	assign take_new  = (ridx_s1 == '0) || (rd_pri > best_pri_q);
	assign scan_end  = rv_s1 && (ridx_s1 == last_idx);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_item.kind == KIND_EXTRACT && count_q != '0) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_MOVE;
				end
			end
			ST_MOVE: state_d = ST_FIN;
			ST_FIN: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake and memory access.
	always_comb begin
		in_ready      = 1'b0;
		res_valid     = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = count_q[ADDR_W-1:0];
		mem_req.wdata = {in_item.value, in_item.priority_req};
		mem_req.re    = 1'b0;
		mem_req.raddr = iss_q[ADDR_W-1:0];
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				mem_req.we = in_valid && in_item.kind == KIND_INSERT && !full;
			end
			ST_SCAN: begin
				mem_req.re = (iss_q < count_q);
			end
			ST_MOVE: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = best_idx_q;
				mem_req.wdata = last_q;
			end
			ST_FIN: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			iss_q   <= '0;
			rv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= mem_req.re;
			if (accept) begin
				iss_q <= '0;
			end else if (mem_req.re) begin
				iss_q <= iss_q + CNT_W'(1);
			end
			if (mem_req.we && state_q == ST_IDLE) begin
				count_q <= count_inc;
			end else if (state_q == ST_MOVE) begin
				count_q <= count_dec;
			end
		end
	end

	// Scan datapath and result.
	always_ff @(posedge clk) begin
		ridx_s1 <= mem_req.raddr;
		if (rv_s1 && take_new) begin
			best_val_q <= rd_val;
			best_pri_q <= rd_pri;
			best_idx_q <= ridx_s1;
		end
		if (scan_end) begin
			last_q <= rdata;
		end
		if (accept) begin
			if (in_item.kind == KIND_INSERT) begin
				if (full) begin
					res_q <= mk_res('0, '0, STAT_FULL, count_q);
				end else begin
					res_q <= mk_res('0, '0, STAT_DONE, count_inc);
				end
			end else if (count_q == '0) begin
				res_q <= mk_res('0, '0, STAT_EMPTY, count_q);
			end
		end else if (state_q == ST_MOVE) begin
			res_q <= mk_res(best_val_q, best_pri_q, STAT_DONE, count_dec);
		end
	end

endmodule

// File: tb/sv/array_max_priority_queue_top_tb.sv
// ----------------------------------------------------------------------------
// array_max_priority_queue_top_tb
// Self-checking bench for the array max-priority queue. A short table of
// directed items covers empty and full rejects, extreme words and priorities,
// and priority ties. Biased random phases then alternately fill and drain the
// queue. Every result is checked field by field against the table's expectation
// or a shadow queue kept in the bench, with random idling on both channels.
// ----------------------------------------------------------------------------
module array_max_priority_queue_top_tb import amq_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_PCT       = 23;
	localparam int RANDOM_ITEMS   = 250;
	localparam int RANDOM_PHASES  = 5;
	localparam int DRAIN_WAIT     = 80;
	localparam int WATCHDOG_LIMIT = 2000;

	// One row of the directed table; reps repeats the row.
	typedef struct {
		logic                    kind;
		logic signed [VAL_W-1:0] value;
		logic [PRI_W-1:0]        prio;
		int                      reps;
		bit                      rand_val;
		bit                      rand_pri;
		bit                      typed;
		res_t                    want;
	} step_t;

	// Typed expectation that travels with an item until it is accepted.
	typedef struct {
		bit   typed;
		res_t want;
	} tag_t;

	logic clk;
	logic arst_n;
	bit   calm;

	amq_req_if req_ch ();
	amq_rsp_if rsp_ch ();

	array_max_priority_queue_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the queue contents.
	logic signed [VAL_W-1:0] shadow_val [CAPACITY];
	logic [PRI_W-1:0]        shadow_pri [CAPACITY];
	int                      shadow_cnt = 0;

	step_t steps [$];
	tag_t  tag_q [$];
	res_t  pending_results [$];

	int errors      = 0;
	int n_inserts   = 0;
	int n_extracts  = 0;
	int n_rej_full  = 0;
	int n_rej_empty = 0;
	int n_full_seen = 0;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one item to the shadow queue and returns the result it yields.
	function automatic res_t pq_next_result(input req_t it);
		res_t r;
		int   best;
		r = '0;
		r.status = STAT_DONE;
		if (it.kind == KIND_INSERT) begin
			if (shadow_cnt >= CAPACITY) begin
				r.status = STAT_FULL;
			end else begin
				shadow_val[shadow_cnt] = it.value;
				shadow_pri[shadow_cnt] = it.priority_req;
				shadow_cnt++;
			end
		end else begin
			if (shadow_cnt == 0) begin
				r.status = STAT_EMPTY;
			end else begin
				// The first entry of highest priority wins; the last one fills the gap.
				best = 0;
				for (int i = 1; i < shadow_cnt; i++) begin
					if (shadow_pri[i] > shadow_pri[best]) best = i;
				end
				r.out_value    = shadow_val[best];
				r.out_priority = shadow_pri[best];
				shadow_val[best] = shadow_val[shadow_cnt-1];
				shadow_pri[best] = shadow_pri[shadow_cnt-1];
				shadow_cnt--;
			end
		end
		r.held     = HELD_W'(shadow_cnt);
		r.is_empty = (shadow_cnt == 0);
		r.is_full  = (shadow_cnt == CAPACITY);
		return r;
	endfunction

	// Builds a result that can be written down directly.
	function automatic res_t known_res(input logic signed [VAL_W-1:0] v,
			input logic [PRI_W-1:0] p, input status_t s, input int held);
		res_t r;
		r.out_value    = v;
		r.out_priority = p;
		r.status       = s;
		r.held         = HELD_W'(held);
		r.is_empty     = (held == 0);
		r.is_full      = (held == CAPACITY);
		return r;
	endfunction

	task automatic add_step(input logic kind, input logic signed [VAL_W-1:0] value,
			input logic [PRI_W-1:0] prio, input int reps, input bit rand_val,
			input bit rand_pri, input bit typed, input res_t want);
		step_t st;
		st.kind     = kind;
		st.value    = value;
		st.prio     = prio;
		st.reps     = reps;
		st.rand_val = rand_val;
		st.rand_pri = rand_pri;
		st.typed    = typed;
		st.want     = want;
		steps.push_back(st);
	endtask

	// Random item; priorities lean toward a narrow band and the extremes so that
	// ties and boundary compares happen often.
	function automatic req_t random_item(input int ins_pct);
		req_t it;
		int   sel;
		it.kind  = ($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_EXTRACT;
		it.value = $urandom;
		sel = $urandom_range(0, 99);
		if (sel < 25)
			it.priority_req = PRI_W'($urandom_range(0, 3));
		else if (sel < 35)
			it.priority_req = sel[0] ? '1 : '0;
		else
			it.priority_req = PRI_W'($urandom_range(0, 65535));
		return it;
	endfunction

	// Offers one item, with an optional random gap first, and waits until it is
	// taken. Valid stays high into the next item when there is no gap.
	task automatic push_item(input req_t it, input bit typed, input res_t want);
		tag_t tg;
		if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
		end
		tg.typed = typed;
		tg.want  = want;
		tag_q.push_back(tg);
		req_ch.valid        <= 1'b1;
		req_ch.kind         <= it.kind;
		req_ch.value        <= it.value;
		req_ch.priority_req <= it.priority_req;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic report_mismatch(input string msg);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
	endtask

	// Result sink: ready drops at random except in the calm stretch.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Monitor: accepted items feed the shadow queue, accepted results are checked.
	always @(posedge clk) begin
		req_t acc;
		res_t pred;
		res_t got;
		res_t want;
		tag_t tg;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				acc.kind         = req_ch.kind;
				acc.value        = req_ch.value;
				acc.priority_req = req_ch.priority_req;
				pred = pq_next_result(acc);
				if (acc.kind == KIND_INSERT) n_inserts++;
				else n_extracts++;
				tg = tag_q.pop_front();
				pending_results.push_back(tg.typed ? tg.want : pred);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.out_value    = rsp_ch.out_value;
				got.out_priority = rsp_ch.out_priority;
				got.status       = rsp_ch.status;
				got.held         = rsp_ch.held;
				got.is_empty     = rsp_ch.is_empty;
				got.is_full      = rsp_ch.is_full;
				if (pending_results.size() == 0) begin
					report_mismatch("result with no item waiting for one");
				end else begin
					want = pending_results.pop_front();
					check_field("out_value", 64'(got.out_value), 64'(want.out_value));
					check_field("out_priority", 64'(got.out_priority),
						64'(want.out_priority));
					check_field("status", 64'(got.status), 64'(want.status));
					check_field("held", 64'(got.held), 64'(want.held));
					check_field("is_empty", 64'(got.is_empty), 64'(want.is_empty));
					check_field("is_full", 64'(got.is_full), 64'(want.is_full));
				end
				if (got.status == STAT_FULL) n_rej_full++;
				if (got.status == STAT_EMPTY) n_rej_empty++;
				if (got.status == STAT_DONE && got.is_full) n_full_seen++;
			end
		end
	end

	// Watchdog on cycles without any handshake.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[%0t] watchdog: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
		$display("FAIL");
		$finish;
	end

	// Stimulus.
	initial begin
		req_t it;
		res_t none;
		int   ins_pct;
		none = '0;
		arst_n              = 1'b0;
		calm                = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.kind         = KIND_INSERT;
		req_ch.value        = '0;
		req_ch.priority_req = '0;

		// Directed table: empty reject, extremes, ties, fill to full, drain.
		add_step(KIND_EXTRACT, 0, 0, 1, 0, 0, 1, known_res(0, 0, STAT_EMPTY, 0));
		add_step(KIND_INSERT, 32'sh7fffffff, 16'hffff, 1, 0, 0, 1,
			known_res(0, 0, STAT_DONE, 1));
		add_step(KIND_INSERT, 32'sh80000000, 16'h0000, 1, 0, 0, 1,
			known_res(0, 0, STAT_DONE, 2));
		add_step(KIND_INSERT, -1, 16'hffff, 1, 0, 0, 1, known_res(0, 0, STAT_DONE, 3));
		add_step(KIND_INSERT, 0, 16'h8000, 1, 0, 0, 1, known_res(0, 0, STAT_DONE, 4));
		// Tie at the top priority: the lower slot goes first.
		add_step(KIND_EXTRACT, 0, 0, 1, 0, 0, 1,
			known_res(32'sh7fffffff, 16'hffff, STAT_DONE, 3));
		add_step(KIND_EXTRACT, 0, 0, 1, 0, 0, 1, known_res(-1, 16'hffff, STAT_DONE, 2));
		add_step(KIND_EXTRACT, 0, 0, 1, 0, 0, 1, known_res(0, 16'h8000, STAT_DONE, 1));
		add_step(KIND_EXTRACT, 0, 0, 1, 0, 0, 1,
			known_res(32'sh80000000, 16'h0000, STAT_DONE, 0));
		// Extract on empty ignores its payload.
		add_step(KIND_EXTRACT, -1, 16'hffff, 1, 0, 0, 1, known_res(0, 0, STAT_EMPTY, 0));
		// Run of equal priorities followed by a lower one, then drain.
		add_step(KIND_INSERT, 0, 16'd3, 6, 1, 0, 0, none);
		add_step(KIND_INSERT, 0, 16'd2, 1, 1, 0, 0, none);
		add_step(KIND_EXTRACT, 0, 0, 7, 1, 1, 0, none);
		// Fill to capacity, then inserts when full are turned away.
		add_step(KIND_INSERT, 0, 0, CAPACITY, 1, 1, 0, none);
		add_step(KIND_INSERT, 32'sh5a5a5a5a, 16'hffff, 1, 0, 0, 1,
			known_res(0, 0, STAT_FULL, CAPACITY));
		add_step(KIND_INSERT, -1, 16'h0000, 1, 0, 0, 1,
			known_res(0, 0, STAT_FULL, CAPACITY));
		add_step(KIND_EXTRACT, 0, 0, CAPACITY, 1, 1, 0, none);
		add_step(KIND_EXTRACT, 0, 0, 1, 0, 0, 1, known_res(0, 0, STAT_EMPTY, 0));

		// Reset.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table.
		foreach (steps[s]) begin
			for (int k = 0; k < steps[s].reps; k++) begin
				it.kind         = steps[s].kind;
				it.value        = steps[s].rand_val ? $urandom : steps[s].value;
				it.priority_req = steps[s].rand_pri ? PRI_W'($urandom_range(0, 65535)) :
					steps[s].prio;
				push_item(it, steps[s].typed, steps[s].want);
			end
		end

		// Random phases alternate between filling and draining; the middle phase
		// is balanced and runs without idling on either side.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph % 5)
				0, 3: begin
					ins_pct = 85;
				end
				2: begin
					ins_pct = 50;
				end
				default: begin
					ins_pct = 15;
				end
			endcase
			calm = (ph == 2);
			for (int k = 0; k < RANDOM_ITEMS / RANDOM_PHASES; k++)
				push_item(random_item(ins_pct), 0, none);
		end
		calm = 1'b0;
		req_ch.valid <= 1'b0;

		// Let the monitor log the last item, then wait for every outstanding
		// result and a little longer.
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d inserts and %0d extracts, queue reached full %0d times",
			n_inserts, n_extracts, n_full_seen);
		$display("rejected %0d inserts when full and %0d extracts when empty, %0d mismatches",
			n_rej_full, n_rej_empty, errors);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
